>>> src/bcws_pkg.sv
// Shared types, constants and channel table for the bonded channel width selector.
`timescale 1ns / 1ps
`default_nettype none

package bcws_pkg;

  // Field widths.
  localparam int ChanW = 8;
  localparam int MaskW = 8;

  // Default number of 20 MHz subchannels in a bonding group.
  localparam int GroupSubchannelsDef = 8;

  // Number of bonding groups in the 5 GHz table.
  localparam int NumGroups = 5;

  // Configuration register indexes.
  localparam logic CFG_PRIMARY_CHANNEL = 1'b0;
  localparam logic CFG_WIDTH_LIMIT     = 1'b1;

  // Register reset values.
  localparam logic [ChanW-1:0] PRIMARY_RESET = 8'd36;
  localparam logic [ChanW-1:0] LIMIT_RESET   = 8'd160;

  // Narrowest channel width in MHz.
  localparam logic [7:0] BASE_WIDTH = 8'd20;

  // Decoded primary channel: its group and place in the group.
  typedef struct packed {
    logic             found;
    logic [ChanW-1:0] base;
    logic [1:0]       levels;
    logic [2:0]       pos;
  } grp_info_t;

  // One result.
  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [7:0]       width;
    logic [MaskW-1:0] mask;
    logic             bad;
  } result_t;

  // First 20 MHz channel of each group.
  function automatic logic [ChanW-1:0] grp_base(input logic [2:0] g);
    logic [ChanW-1:0] b;
    case (g)
      3'd0:    b = 8'd36;
      3'd1:    b = 8'd100;
      3'd2:    b = 8'd132;
      3'd3:    b = 8'd149;
      3'd4:    b = 8'd165;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // Last 20 MHz channel of each group.
  function automatic logic [ChanW-1:0] grp_last(input logic [2:0] g);
    logic [ChanW-1:0] l;
    case (g)
      3'd0:    l = 8'd64;
      3'd1:    l = 8'd128;
      3'd2:    l = 8'd144;
      3'd3:    l = 8'd161;
      3'd4:    l = 8'd165;
      default: l = 8'd0;
    endcase
    return l;
  endfunction

  // Tree depth of each group: 0 means a lone 20 MHz channel, 3 means 160 MHz at the top.
  function automatic logic [1:0] grp_levels(input logic [2:0] g);
    logic [1:0] lv;
    case (g)
      3'd0:    lv = 2'd3;
      3'd1:    lv = 2'd3;
      3'd2:    lv = 2'd2;
      3'd3:    lv = 2'd2;
      default: lv = 2'd0;
    endcase
    return lv;
  endfunction

  // Subchannels covered by the tree node at the given level that holds position pos.
  function automatic logic [MaskW-1:0] block_mask(input logic [2:0] pos, input logic [1:0] lvl);
    logic [MaskW-1:0] m;
    case (lvl)
      2'd0:    m = 8'h01 << pos;
      2'd1:    m = 8'h03 << {pos[2:1], 1'b0};
      2'd2:    m = 8'h0F << {pos[2], 2'b00};
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> src/bonded_channel_width_select.sv
// Top level of the bonded channel width selector.
//
// Picks the widest usable bonded 5 GHz channel around the configured 20 MHz
// primary. Each request carries an idle mask, a received mask and a mode bit.
// A request is taken at a rising edge with req_valid high and req_stall low,
// and a result leaves at an edge with res_valid high and res_stall low.
// Configuration writes use cfg_valid and cfg_ready; cfg_ready is always high,
// and index 0 is the primary channel, index 1 the width limit. The user must
// write the registers only while no request is in flight; the block itself
// does not enforce it. A request passes through the input register, the group
// decode and tree walk, then the result register. The block takes one request
// per cycle, back to back, as long as results are taken.
// When the receiver stalls, the result register holds its value and the input
// register, if empty, still takes one more request; after that req_stall goes
// high until the result is taken.
// Reset is synchronous: both pipeline valid flags clear, the primary channel
// returns to 36 and the width limit to 160 MHz.
`timescale 1ns / 1ps
`default_nettype none

module bonded_channel_width_select
  import bcws_pkg::*;
#(
  parameter int GROUP_SUBCHANNELS = GroupSubchannelsDef
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Configuration write channel.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_data,
  // Request channel.
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire logic [MaskW-1:0] idle_mask,
  input  wire logic [MaskW-1:0] received_mask,
  input  wire logic             use_rts_cts,
  // Result channel.
  output logic                  res_valid,
  input  wire logic             res_stall,
  output logic [ChanW-1:0]      bonded_channel,
  output logic [7:0]            bonded_width,
  output logic [MaskW-1:0]      subchannel_mask,
  output logic                  bad_channel
);

  logic [ChanW-1:0] primary_channel;
  logic [7:0]       width_limit;

  // Input register.
  logic             s1_valid;
  logic [MaskW-1:0] s1_idle;
  logic [MaskW-1:0] s1_recv;
  logic             s1_rts;

  grp_info_t info;
  result_t   result;
  logic      out_free;
  logic      accept;

  assign cfg_ready = 1'b1;

  // The result register can load when it is empty or being drained this cycle.
  assign out_free  = !res_valid || !res_stall;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_channel <= PRIMARY_RESET;
      width_limit     <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRIMARY_CHANNEL: primary_channel <= cfg_data;
        CFG_WIDTH_LIMIT:     width_limit     <= cfg_data;
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idle <= idle_mask;
      s1_recv <= received_mask;
      s1_rts  <= use_rts_cts;
    end
  end

  bcws_decode u_decode (
    .primary_channel (primary_channel),
    .info            (info)
  );

  bcws_walk #(
    .GROUP_SUBCHANNELS (GROUP_SUBCHANNELS)
  ) u_walk (
    .info          (info),
    .width_limit   (width_limit),
    .idle_mask     (s1_idle),
    .received_mask (s1_recv),
    .use_rts_cts   (s1_rts),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      bonded_channel  <= result.channel;
      bonded_width    <= result.width;
      subchannel_mask <= result.mask;
      bad_channel     <= result.bad;
    end
  end

endmodule

`default_nettype wire

>>> src/bcws_decode.sv
// Primary channel decoder: finds the bonding group and subchannel position.
`timescale 1ns / 1ps
`default_nettype none

module bcws_decode
  import bcws_pkg::*;
(
  input  wire logic [ChanW-1:0] primary_channel,
  output grp_info_t             info
);

  always_comb begin
    logic [ChanW-1:0] diff;
    info = '0;
    diff = '0;
    // The groups do not overlap, so at most one of them matches.
    for (int g = 0; g < NumGroups; g++) begin
      diff = primary_channel - grp_base(3'(g));
      if (primary_channel >= grp_base(3'(g)) && primary_channel <= grp_last(3'(g)) &&
          diff[1:0] == 2'b00) begin
        info.found  = 1'b1;
        info.base   = grp_base(3'(g));
        info.levels = grp_levels(3'(g));
        info.pos    = diff[4:2];
      end
    end
  end

endmodule

`default_nettype wire

>>> src/bcws_walk.sv
// Bonding tree walk: climbs from the primary while siblings and limit allow.
`timescale 1ns / 1ps
`default_nettype none

module bcws_walk
  import bcws_pkg::*;
#(
  parameter int GROUP_SUBCHANNELS = GroupSubchannelsDef
) (
  input  wire grp_info_t        info,
  input  wire logic [7:0]       width_limit,
  input  wire logic [MaskW-1:0] idle_mask,
  input  wire logic [MaskW-1:0] received_mask,
  input  wire logic             use_rts_cts,
  output result_t               result
);

  localparam logic [MaskW:0]   ValidWide = (9'd1 << GROUP_SUBCHANNELS) - 9'd1;
  localparam logic [MaskW-1:0] ValidBits = ValidWide[MaskW-1:0];

  always_comb begin
    logic [MaskW-1:0] src;
    logic [MaskW-1:0] cur;
    logic [MaskW-1:0] sib;
    logic [7:0]       top;
    logic [7:0]       lim;
    logic [7:0]       wd;
    logic [1:0]       lvl;
    logic [2:0]       start;
    logic [3:0]       span;
    logic             stop;

    src   = (use_rts_cts ? received_mask : idle_mask) & ValidBits;
    top   = BASE_WIDTH << info.levels;
    lim   = (width_limit > top) ? top : width_limit;
    lvl   = 2'd0;
    stop  = 1'b0;
    cur   = '0;
    sib   = '0;
    wd    = '0;

    // At most three steps up the tree.
    for (int k = 0; k < 3; k++) begin
      wd = BASE_WIDTH << k;
      if (!stop) begin
        if (2'(k) >= info.levels) begin
          stop = 1'b1;
        end else if (use_rts_cts ? (wd >= lim) : (wd == lim)) begin
          stop = 1'b1;
        end else begin
          cur = block_mask(info.pos, 2'(k));
          sib = block_mask(info.pos, 2'(k + 1)) & ~cur;
          if ((src & sib) != sib) begin
            stop = 1'b1;
          end else begin
            lvl = 2'(k + 1);
          end
        end
      end
    end

    start = info.pos & ~((3'd1 << lvl) - 3'd1);
    span  = (4'd1 << lvl) - 4'd1;

    result.bad     = 1'b0;
    result.channel = info.base + {3'b000, start, 2'b00} + {3'b000, span, 1'b0};
    result.width   = BASE_WIDTH << lvl;
    result.mask    = block_mask(info.pos, lvl);

    if (!info.found) begin
      result = '0;
      result.bad = 1'b1;
    end else if (use_rts_cts && !src[info.pos]) begin
      // The primary itself was not received: nothing is usable.
      result = '0;
    end
  end

endmodule

`default_nettype wire

>>> src/bcws_checker.sv
// Port-level checker for the bonded channel width selector, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module bcws_checker
  import bcws_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_stall,
  input wire logic             res_valid,
  input wire logic             res_stall,
  input wire logic [ChanW-1:0] bonded_channel,
  input wire logic [7:0]       bonded_width,
  input wire logic [MaskW-1:0] subchannel_mask,
  input wire logic             bad_channel
);

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(bonded_channel) &&
      $stable(bonded_width) && $stable(subchannel_mask) && $stable(bad_channel))
  else $error("stalled result changed");

  // Requests are held back only while a result is blocked at the output.
  assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
  else $error("request stalled with a free output");

  // A bad primary yields an empty selection.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && bad_channel |->
      bonded_channel == 8'd0 && bonded_width == 8'd0 && subchannel_mask == 8'd0)
  else $error("bad primary with a non-empty selection");

  // The subchannel count matches the bonded width, and no width means no channel.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      (bonded_width == 8'd0 && subchannel_mask == 8'd0 && bonded_channel == 8'd0) ||
      (bonded_width == 8'd20 && $countones(subchannel_mask) == 1) ||
      (bonded_width == 8'd40 && $countones(subchannel_mask) == 2) ||
      (bonded_width == 8'd80 && $countones(subchannel_mask) == 4) ||
      (bonded_width == 8'd160 && $countones(subchannel_mask) == 8))
  else $error("bonded width and subchannel mask disagree");

endmodule

bind bonded_channel_width_select bcws_checker u_bcws_checker (
  .clk             (clk),
  .rst             (rst),
  .req_stall       (req_stall),
  .res_valid       (res_valid),
  .res_stall       (res_stall),
  .bonded_channel  (bonded_channel),
  .bonded_width    (bonded_width),
  .subchannel_mask (subchannel_mask),
  .bad_channel     (bad_channel)
);

`default_nettype wire

>>> sim/tb_bonded_channel_width_select.sv
// Self-checking testbench for the bonded channel width selector.
`timescale 1ns / 1ps

// The run starts with a short directed part: the idle and received walks up
// to each width, a primary that was not received, a limit that is not a tree
// width, a limit above the group top, the lone 165 channel, and primaries
// that are not 20 MHz table channels. Random phases follow. Each phase
// reprograms both registers while the block is drained, then sends a batch of
// requests whose masks are shaped so the tree walk often climbs several
// levels. The driver and the receiver insert short random bursts of idling,
// and the last phase runs without any. Every result is predicted when its
// request is accepted and checked field by field, in order, when it leaves.
module tb_bonded_channel_width_select;
  import bcws_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [MaskW-1:0] idle;
    logic [MaskW-1:0] recv;
    logic             rts;
  } request_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_index = CFG_PRIMARY_CHANNEL;
  logic [7:0]       cfg_data = '0;
  logic             req_valid = 1'b0;
  logic [MaskW-1:0] idle_mask = '0;
  logic [MaskW-1:0] received_mask = '0;
  logic             use_rts_cts = 1'b0;
  logic             res_stall = 1'b0;

  logic             cfg_ready;
  logic             req_stall;
  logic             res_valid;
  logic [ChanW-1:0] bonded_channel;
  logic [7:0]       bonded_width;
  logic [MaskW-1:0] subchannel_mask;
  logic             bad_channel;

  // Requests waiting to be driven, and the results owed by accepted requests.
  request_t pending_q[$];
  result_t  owed_results_q[$];

  // Our own copy of the configuration registers.
  logic [7:0] primary_reg;
  logic [7:0] limit_reg;

  int driven_count = 0;
  int accepted_count = 0;
  int cfg_writes = 0;
  int errors = 0;

  // Idling odds in percent, per request for gaps and per cycle for stalls, set by each phase; zero means none.
  int gap_pct = 0;
  int stall_pct = 0;
  int send_gap = 0;
  int stall_left = 0;

  bonded_channel_width_select u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .idle_mask      (idle_mask),
    .received_mask  (received_mask),
    .use_rts_cts    (use_rts_cts),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .bonded_channel (bonded_channel),
    .bonded_width   (bonded_width),
    .subchannel_mask(subchannel_mask),
    .bad_channel    (bad_channel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Subchannels under the tree node of the given level that holds position pos.
  function automatic logic [7:0] span_of(input int pos, input int lvl);
    int size;
    int start;
    size  = 1 << lvl;
    start = pos & ~(size - 1);
    return 8'(((1 << size) - 1) << start);
  endfunction

  // Expected result for one request under the current register values.
  function automatic result_t pick_bonded_channel(input logic [7:0] prim,
                                                  input logic [7:0] limit,
                                                  input request_t   rq);
    int g;
    int first;
    int depth;
    int last;
    int base;
    int levels;
    int pos;
    int cap;
    int lvl;
    int size;
    bit found;
    bit stop;
    logic [7:0] src;
    logic [7:0] sib;
    result_t r;
    r = '0;
    found = 1'b0;
    base = 0;
    levels = 0;
    pos = 0;
    first = 0;
    depth = 0;
    // Locate the primary in the group table: first channel and tree depth.
    for (g = 0; g < 5; g++) begin
      case (g)
        0: begin first = 36;  depth = 3; end
        1: begin first = 100; depth = 3; end
        2: begin first = 132; depth = 2; end
        3: begin first = 149; depth = 2; end
        default: begin first = 165; depth = 0; end
      endcase
      last = first + 4 * ((1 << depth) - 1);
      if (int'(prim) >= first && int'(prim) <= last && ((int'(prim) - first) % 4) == 0) begin
        found  = 1'b1;
        base   = first;
        levels = depth;
        pos    = (int'(prim) - first) / 4;
      end
    end
    if (!found) begin
      r.bad = 1'b1;
      return r;
    end
    cap = int'(limit);
    if (cap > (20 << levels)) cap = 20 << levels;
    // In RTS/CTS mode nothing is usable unless the primary itself was received.
    if (rq.rts && !rq.recv[pos]) return r;
    src = rq.rts ? rq.recv : rq.idle;
    lvl = 0;
    stop = 1'b0;
    while (!stop) begin
      if (lvl >= levels) begin
        stop = 1'b1;
      end else if (rq.rts ? ((20 << lvl) >= cap) : ((20 << lvl) == cap)) begin
        stop = 1'b1;
      end else begin
        sib = span_of(pos, lvl + 1) & ~span_of(pos, lvl);
        if ((src & sib) != sib) stop = 1'b1;
        else lvl++;
      end
    end
    size = 1 << lvl;
    r.channel = 8'(base + 4 * (pos & ~(size - 1)) + 2 * (size - 1));
    r.width   = 8'(20 << lvl);
    r.mask    = span_of(pos, lvl);
    return r;
  endfunction

  // Request driver: holds a request until it is taken, then moves on to the
  // next pending one, now and then leaving a short gap.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accepted_count != driven_count) begin
      // The request on the bus has not been taken yet; keep it steady.
    end else if (send_gap > 0) begin
      send_gap--;
      req_valid <= 1'b0;
    end else if (pending_q.size() > 0) begin
      nxt = pending_q.pop_front();
      idle_mask     <= nxt.idle;
      received_mask <= nxt.recv;
      use_rts_cts   <= nxt.rts;
      req_valid     <= 1'b1;
      driven_count++;
      if ($urandom_range(0, 99) < gap_pct) send_gap = $urandom_range(1, 3);
    end else begin
      req_valid <= 1'b0;
    end
  end

  // Result receiver: raises res_stall in random bursts, started at the odds set in stall_pct.
  always @(negedge clk) begin : drive_stall
    if (rst) begin
      res_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 2);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Monitor: tracks register writes, predicts at request acceptance, and
  // checks each result against the oldest prediction.
  always @(posedge clk) begin : watch_ports
    result_t want;
    if (rst) begin
      primary_reg = PRIMARY_RESET;
      limit_reg   = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRIMARY_CHANNEL) primary_reg = cfg_data;
        else limit_reg = cfg_data;
        cfg_writes++;
      end
      if (req_valid && !req_stall) begin
        owed_results_q = {owed_results_q,
                          pick_bonded_channel(primary_reg, limit_reg,
                                              {idle_mask, received_mask, use_rts_cts})};
        accepted_count++;
      end
      if (res_valid && !res_stall) begin
        if (owed_results_q.size() == 0) begin
          $error("result with no request outstanding: bonded_channel %0d", bonded_channel);
          errors++;
        end else begin
          want = owed_results_q.pop_front();
          if (bonded_channel !== want.channel) begin
            $error("bonded_channel: expected %0d, got %0d", want.channel, bonded_channel);
            errors++;
          end
          if (bonded_width !== want.width) begin
            $error("bonded_width: expected %0d, got %0d", want.width, bonded_width);
            errors++;
          end
          if (subchannel_mask !== want.mask) begin
            $error("subchannel_mask: expected %h, got %h", want.mask, subchannel_mask);
            errors++;
          end
          if (bad_channel !== want.bad) begin
            $error("bad_channel: expected %0b, got %0b", want.bad, bad_channel);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    int n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("FAIL bonded_channel_width_select");
    $finish;
  end

  task automatic queue_request(input logic [7:0] idle, input logic [7:0] recv,
                               input logic rts);
    request_t rq;
    rq.idle = idle;
    rq.recv = recv;
    rq.rts  = rts;
    pending_q = {pending_q, rq};
  endtask

  // Blocks until every request is sent and every owed result has arrived.
  // Each request yields exactly one result, so an empty store means idle.
  task automatic wait_for_drain();
    while (pending_q.size() != 0 || accepted_count != driven_count ||
           owed_results_q.size() != 0)
      @(negedge clk);
  endtask

  // One register write; the monitor's write count tells when it was taken.
  task automatic write_register(input logic idx, input logic [7:0] val);
    int seen;
    @(negedge clk);
    seen = cfg_writes;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // Masks biased toward mostly set bits, so sibling halves are often complete
  // and the walk gets past the lower levels; one case in four is plain noise.
  function automatic logic [7:0] shaped_mask();
    logic [7:0] m;
    case ($urandom_range(0, 3))
      0:       m = 8'($urandom);
      1:       m = 8'($urandom | $urandom);
      2:       m = 8'hFF & ~(8'h01 << $urandom_range(0, 7));
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

  // A 20 MHz channel drawn evenly from the whole table.
  function automatic logic [7:0] table_channel();
    int k;
    k = $urandom_range(0, 24);
    if (k < 8) return 8'(36 + 4 * k);
    if (k < 16) return 8'(100 + 4 * (k - 8));
    if (k < 20) return 8'(132 + 4 * (k - 16));
    if (k < 24) return 8'(149 + 4 * (k - 20));
    return 8'd165;
  endfunction

  function automatic logic [7:0] pick_limit();
    logic [7:0] v;
    case ($urandom_range(0, 7))
      0:       v = 8'd20;
      1:       v = 8'd40;
      2:       v = 8'd80;
      3:       v = 8'd160;
      4:       v = 8'd0;
      5:       v = 8'd255;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic int pick_pct();
    int v;
    case ($urandom_range(0, 3))
      0:       v = 0;
      1:       v = 10;
      2:       v = 30;
      default: v = 60;
    endcase
    return v;
  endfunction

  initial begin : run_test
    int ph;
    int k;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: primary 36, limit 160. Idle walk to each width, then
    // the received walk, a primary that was not received, and a received
    // mask whose upper half is incomplete.
    gap_pct = 30;
    stall_pct = 30;
    queue_request(8'h00, 8'h00, 1'b0);
    queue_request(8'hFF, 8'hFF, 1'b0);
    queue_request(8'h02, 8'h00, 1'b0);
    queue_request(8'h0E, 8'h00, 1'b0);
    queue_request(8'hFE, 8'h00, 1'b0);
    queue_request(8'hF2, 8'h00, 1'b0);
    queue_request(8'h00, 8'h01, 1'b1);
    queue_request(8'h00, 8'h03, 1'b1);
    queue_request(8'h00, 8'h0F, 1'b1);
    queue_request(8'h00, 8'hFF, 1'b1);
    queue_request(8'hFF, 8'hFE, 1'b1);
    queue_request(8'hFF, 8'h7F, 1'b1);
    wait_for_drain();

    // A tree width as the limit stops both modes there.
    write_register(CFG_WIDTH_LIMIT, 8'd40);
    queue_request(8'hFF, 8'hFF, 1'b0);
    queue_request(8'hFF, 8'hFF, 1'b1);
    wait_for_drain();

    // A limit that is no tree width: the idle walk never matches it and
    // climbs to the top, the received walk stops at the first width above.
    write_register(CFG_WIDTH_LIMIT, 8'd30);
    queue_request(8'hFF, 8'hFF, 1'b0);
    queue_request(8'hFF, 8'hFF, 1'b1);
    wait_for_drain();

    write_register(CFG_WIDTH_LIMIT, 8'd0);
    queue_request(8'hFF, 8'hFF, 1'b0);
    queue_request(8'hFF, 8'hFF, 1'b1);
    wait_for_drain();

    // Last channel of an 80 MHz group with the limit far above its top.
    write_register(CFG_PRIMARY_CHANNEL, 8'd161);
    write_register(CFG_WIDTH_LIMIT, 8'd255);
    queue_request(8'hFF, 8'hFF, 1'b0);
    queue_request(8'h00, 8'h08, 1'b1);
    wait_for_drain();

    // The lone 20 MHz channel, including a primary that was not received.
    write_register(CFG_PRIMARY_CHANNEL, 8'd165);
    queue_request(8'hFF, 8'hFF, 1'b0);
    queue_request(8'hFF, 8'hFE, 1'b1);
    wait_for_drain();

    // Primaries that are not 20 MHz table channels.
    write_register(CFG_PRIMARY_CHANNEL, 8'd37);
    queue_request(8'hFF, 8'hFF, 1'b0);
    wait_for_drain();
    write_register(CFG_PRIMARY_CHANNEL, 8'd0);
    queue_request(8'hFF, 8'hFF, 1'b1);
    wait_for_drain();
    write_register(CFG_PRIMARY_CHANNEL, 8'd255);
    queue_request(8'h00, 8'h00, 1'b0);
    wait_for_drain();

    // Random phases. Each drains completely before the next register writes,
    // which also makes the sender pause until every result is back.
    for (ph = 0; ph < 24; ph++) begin
      if ($urandom_range(0, 9) < 8) write_register(CFG_PRIMARY_CHANNEL, table_channel());
      else write_register(CFG_PRIMARY_CHANNEL, 8'($urandom));
      write_register(CFG_WIDTH_LIMIT, pick_limit());
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      for (k = 0; k < 30; k++)
        queue_request(shaped_mask(), shaped_mask(), 1'($urandom));
      wait_for_drain();
    end

    // Closing phase at full rate on both sides.
    gap_pct = 0;
    stall_pct = 0;
    write_register(CFG_PRIMARY_CHANNEL, table_channel());
    write_register(CFG_WIDTH_LIMIT, pick_limit());
    for (k = 0; k < 30; k++)
      queue_request(shaped_mask(), shaped_mask(), 1'($urandom));
    wait_for_drain();

    // A few more cycles so that any stray result would still be seen.
    repeat (6) @(negedge clk);
    if (errors == 0 && owed_results_q.size() == 0) begin
      $display("PASS bonded_channel_width_select");
    end else begin
      $display("FAIL bonded_channel_width_select");
    end
    $finish;
  end

endmodule
